### hdl/oaids_pkg.sv
// Shared constants, codes and types for the ordered array block.
package oaids_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int FUNC_W   = 2;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 4;
    localparam int DOUT_W   = 32;
    localparam int LEN_W    = 5;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic commit_ins;
        logic commit_del;
        logic scan_search;
        logic scan_pick;
    } cell_ctrl_t;

endpackage

### hdl/oaids_req_if.sv
// Request channel: operation word into the block.
interface oaids_req_if;
    logic                               valid;
    logic                               ready;
    logic [oaids_pkg::FUNC_W-1:0]       func;
    logic [oaids_pkg::POS_W-1:0]        position;
    logic signed [oaids_pkg::VALUE_W-1:0] value;

    modport source (output valid, output func, output position, output value, input ready);
    modport sink   (input valid, input func, input position, input value, output ready);
endinterface

### hdl/oaids_rsp_if.sv
// Response channel: result word out of the block.
interface oaids_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [oaids_pkg::STATUS_W-1:0]      status;
    logic                                found;
    logic [oaids_pkg::FIDX_W-1:0]        found_index;
    logic signed [oaids_pkg::DOUT_W-1:0] data_out;
    logic [oaids_pkg::LEN_W-1:0]         length;

    modport source (output valid, output status, output found, output found_index,
                    output data_out, output length, input ready);
    modport sink   (input valid, input status, input found, input found_index,
                    input data_out, input length, output ready);
endinterface

### hdl/oaids_cell.sv
// One array cell: holds an entry, shifts with its neighbors, passes the scan word on.
module oaids_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = oaids_pkg::DATA_WIDTH_DEFAULT,
    parameter int IDX_W      = 4,
    parameter int CMP_W      = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  oaids_pkg::cell_ctrl_t  ctrl,
    input  logic [CMP_W-1:0]       pos,
    input  logic [CMP_W-1:0]       cnt,
    input  logic [DATA_WIDTH-1:0]  val,
    input  logic [DATA_WIDTH-1:0]  left_entry,
    input  logic [DATA_WIDTH-1:0]  right_entry,
    output logic [DATA_WIDTH-1:0]  entry,
    input  logic                   hit_in,
    input  logic [IDX_W-1:0]       idx_in,
    input  logic [DATA_WIDTH-1:0]  data_in,
    output logic                   hit_out,
    output logic [IDX_W-1:0]       idx_out,
    output logic [DATA_WIDTH-1:0]  data_out
);

    localparam logic [CMP_W-1:0] MY_POS = CMP_W'(INDEX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  live;
    logic                  take;

    assign entry    = entry_reg;
    assign hit_out  = hit_reg;
    assign idx_out  = idx_reg;
    assign data_out = data_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.commit_ins)
        begin
            if (MY_POS > pos)
            begin
                entry_next = left_entry;
            end
            else if (MY_POS == pos)
            begin
                entry_next = val;
            end
        end
        else if (ctrl.commit_del)
        begin
            if (MY_POS >= pos)
            begin
                entry_next = right_entry;
            end
        end
    end

    // first qualifying cell along the chain claims the scan word
    always_comb
    begin
        live = MY_POS < cnt;
        take = !hit_in && live &&
               ((ctrl.scan_search && (entry_reg == val)) ||
                (ctrl.scan_pick && (MY_POS == pos)));
        hit_next  = hit_in || take;
        idx_next  = take ? MY_IDX : idx_in;
        data_next = take ? entry_reg : data_in;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        idx_reg   <= idx_next;
        data_reg  <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

endmodule

### hdl/ordered_array_insert_delete_search.sv
// Top level of the ordered array: cell row, scan sequencing, count and result register.
//
// Keeps up to DEPTH words in a row of cells, packed from index 0. One operation is
// handled at a time: after a request word is accepted, a scan word walks down the row
// one cell per clock, then the insert or delete shift is applied to all cells at once
// and the response word is registered; the block can accept the next request in the
// same cycle in which the response appears. The walk of the scan word through the cell
// row sets when the response appears, unless a response held back stalls the commit.
// A new request may be accepted while the previous response still waits to be taken;
// a response held back stalls the commit of the following operation. Cell entries are
// undefined after reset; the count is cleared, so no entry beyond it is ever returned.
module ordered_array_insert_delete_search #(
    parameter int DEPTH      = oaids_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = oaids_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    oaids_req_if.sink    req,
    oaids_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > oaids_pkg::POS_W) ? CNT_W : oaids_pkg::POS_W;

    logic                              busy_reg;
    logic                              busy_next;
    logic [CNT_W-1:0]                  step_reg;
    logic [CNT_W-1:0]                  step_next;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic [oaids_pkg::FUNC_W-1:0]      func_reg;
    logic [oaids_pkg::POS_W-1:0]       pos_reg;
    logic [DATA_WIDTH-1:0]             val_reg;

    logic                              rsp_valid_reg;
    logic                              rsp_valid_next;
    logic [oaids_pkg::STATUS_W-1:0]    status_reg;
    logic [oaids_pkg::STATUS_W-1:0]    status_next;
    logic                              found_reg;
    logic                              found_next;
    logic [oaids_pkg::FIDX_W-1:0]      fidx_reg;
    logic [oaids_pkg::FIDX_W-1:0]      fidx_next;
    logic [oaids_pkg::DOUT_W-1:0]      dout_reg;
    logic [oaids_pkg::DOUT_W-1:0]      dout_next;
    logic [oaids_pkg::LEN_W-1:0]       len_reg;
    logic [oaids_pkg::LEN_W-1:0]       len_next;

    logic                              accept;
    logic                              scan_done;
    logic                              commit;
    logic                              ins_ok;
    logic                              del_ok;
    logic [CMP_W-1:0]                  pos_x;
    logic [CMP_W-1:0]                  cnt_x;
    logic [63:0]                       val_wide;
    logic [63:0]                       data_wide;
    logic [63:0]                       idx_wide;
    logic [63:0]                       len_wide;
    oaids_pkg::cell_ctrl_t             ctrl;

    logic [DATA_WIDTH-1:0]             entry_w [DEPTH];
    logic                              hit_c   [DEPTH+1];
    logic [IDX_W-1:0]                  idx_c   [DEPTH+1];
    logic [DATA_WIDTH-1:0]             data_c  [DEPTH+1];

    assign req.ready = !busy_reg;
    assign accept    = req.valid && !busy_reg;
    assign scan_done = busy_reg && (step_reg == CNT_W'(DEPTH));
    assign commit    = scan_done && (!rsp_valid_reg || rsp.ready);

    assign pos_x    = CMP_W'(pos_reg);
    assign cnt_x    = CMP_W'(count_reg);
    assign val_wide = {32'b0, req.value};

    assign hit_c[0]  = 1'b0;
    assign idx_c[0]  = '0;
    assign data_c[0] = '0;

    always_comb
    begin
        ctrl.commit_ins  = commit && ins_ok;
        ctrl.commit_del  = commit && del_ok;
        ctrl.scan_search = (func_reg == oaids_pkg::FUNC_SEARCH);
        ctrl.scan_pick   = (func_reg == oaids_pkg::FUNC_DELETE) ||
                           (func_reg == oaids_pkg::FUNC_READ);
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = entry_w[i];
        end
        else
        begin : g_mid_l
            assign left_w = entry_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = entry_w[i];
        end
        else
        begin : g_mid_r
            assign right_w = entry_w[i+1];
        end

        oaids_cell #(
            .INDEX      (i),
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .CMP_W      (CMP_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .pos         (pos_x),
            .cnt         (cnt_x),
            .val         (val_reg),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entry_w[i]),
            .hit_in      (hit_c[i]),
            .idx_in      (idx_c[i]),
            .data_in     (data_c[i]),
            .hit_out     (hit_c[i+1]),
            .idx_out     (idx_c[i+1]),
            .data_out    (data_c[i+1])
        );
    end

    always_comb
    begin
        ins_ok      = 1'b0;
        del_ok      = 1'b0;
        status_next = oaids_pkg::STATUS_OK;
        found_next  = 1'b0;
        idx_wide    = '0;
        data_wide   = '0;
        count_next  = count_reg;
        unique case (func_reg)
            oaids_pkg::FUNC_INSERT:
            begin
                if (count_reg == CNT_W'(DEPTH))
                begin
                    status_next = oaids_pkg::STATUS_FULL;
                end
                else if (pos_x > cnt_x)
                begin
                    status_next = oaids_pkg::STATUS_RANGE;
                end
                else
                begin
                    ins_ok     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            oaids_pkg::FUNC_DELETE:
            begin
                if (pos_x >= cnt_x)
                begin
                    status_next = oaids_pkg::STATUS_RANGE;
                end
                else
                begin
                    del_ok     = 1'b1;
                    data_wide  = 64'(data_c[DEPTH]);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            oaids_pkg::FUNC_SEARCH:
            begin
                found_next = hit_c[DEPTH];
                if (hit_c[DEPTH])
                begin
                    idx_wide = 64'(idx_c[DEPTH]);
                end
            end
            oaids_pkg::FUNC_READ:
            begin
                if (pos_x >= cnt_x)
                begin
                    status_next = oaids_pkg::STATUS_RANGE;
                end
                else
                begin
                    data_wide = 64'(data_c[DEPTH]);
                end
            end
            default:
            begin
                status_next = oaids_pkg::STATUS_OK;
            end
        endcase
        len_wide  = 64'(count_next);
        fidx_next = idx_wide[oaids_pkg::FIDX_W-1:0];
        dout_next = data_wide[oaids_pkg::DOUT_W-1:0];
        len_next  = len_wide[oaids_pkg::LEN_W-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (commit)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && !scan_done)
        begin
            step_next = step_reg + CNT_W'(1);
        end

        rsp_valid_next = rsp_valid_reg;
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
            if (commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= req.func;
            pos_reg  <= req.position;
            val_reg  <= val_wide[DATA_WIDTH-1:0];
        end
        if (commit)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            fidx_reg   <= fidx_next;
            dout_reg   <= dout_next;
            len_reg    <= len_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found       = found_reg;
    assign rsp.found_index = fidx_reg;
    assign rsp.data_out    = dout_reg;
    assign rsp.length      = len_reg;

endmodule
